@@ src/touch_swipe_tap_recognizer_assert.svh @@
// Assertion macros used by the checker of the touch recognizer.
`ifndef TOUCH_SWIPE_TAP_RECOGNIZER_ASSERT_SVH
`define TOUCH_SWIPE_TAP_RECOGNIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSTR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("touch recognizer check failed");

// Consequent must hold in the cycle after the antecedent.
`define TSTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("touch recognizer check failed");

`endif

@@ src/tstr_pkg.sv @@
// Package: types, field widths and codes of the touch swipe and tap recognizer.
package tstr_pkg;

  localparam int COORD_BITS = 11;
  localparam int DIM_BITS   = 11;
  localparam int STEP_BITS  = 8;
  localparam int TICK_BITS  = 16;
  localparam int TIME_BITS  = 32;
  localparam int PROD_BITS  = COORD_BITS + STEP_BITS;
  localparam int CNT_BITS   = $clog2(STEP_BITS);

  localparam int MOVE_LIMIT = 20;
  localparam int TAP_MIN_MS = 50;

  // Gesture direction codes.
  localparam logic [2:0] DIR_STAY    = 3'd0;
  localparam logic [2:0] DIR_REQUEST = 3'd1;
  localparam logic [2:0] DIR_LEFT    = 3'd2;
  localparam logic [2:0] DIR_RIGHT   = 3'd3;
  localparam logic [2:0] DIR_UP      = 3'd4;
  localparam logic [2:0] DIR_DOWN    = 3'd5;

  // Display mode codes.
  localparam logic [1:0] MODE_PLAYER   = 2'd0;
  localparam logic [1:0] MODE_VOLUME   = 2'd1;
  localparam logic [1:0] MODE_STATIONS = 2'd2;

  // Mode request codes.
  localparam logic [1:0] REQ_NONE     = 2'd0;
  localparam logic [1:0] REQ_VOLUME   = 2'd1;
  localparam logic [1:0] REQ_STATIONS = 2'd2;
  localparam logic [1:0] REQ_PLAYER   = 2'd3;

  // Step event codes.
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_DEC  = 2'd1;
  localparam logic [1:0] STEP_INC  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_SWIPE_STEPS   = 3'd2;
  localparam logic [2:0] CFG_PRESS_TICKS   = 3'd3;
  localparam logic [2:0] CFG_DIM_ENABLE    = 3'd4;

  typedef struct packed {
    logic                  touched;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [TIME_BITS-1:0]  now_ms;
    logic [1:0]            display_mode;
    logic                  bl_dimmed;
    logic                  bl_fading;
    logic                  bl_just_woke;
  } poll_t;

  typedef struct packed {
    logic [1:0] mode_request;
    logic [1:0] step_event;
    logic       click;
    logic       wake;
    logic       activity;
  } result_t;

  // Request to the serial length unit.
  typedef struct packed {
    logic                  start;
    logic [COORD_BITS-1:0] span;
    logic [STEP_BITS-1:0]  steps;
    logic [DIM_BITS-1:0]   divisor;
  } mul_req_t;

  // Status of the serial length unit; ge is valid while done is high.
  typedef struct packed {
    logic done;
    logic ge;
  } mul_sta_t;

endpackage

@@ src/tstr_mul.sv @@
// Bit-serial shift-add multiplier that tests span * steps >= 2 * divisor.
module tstr_mul
  import tstr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_sta_t sta
);

  logic                 busy;
  logic                 done;
  logic [CNT_BITS-1:0]  cnt;
  logic [PROD_BITS-1:0] acc;
  logic [PROD_BITS-1:0] mcand;
  logic [STEP_BITS-1:0] mplier;
  logic [DIM_BITS-1:0]  divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_BITS'(STEP_BITS - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // One multiplier bit is consumed per cycle, least significant first.
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc     <= '0;
      mcand   <= PROD_BITS'(req.span);
      mplier  <= req.steps;
      divisor <= req.divisor;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[PROD_BITS-2:0], 1'b0};
      mplier <= {1'b0, mplier[STEP_BITS-1:1]};
    end
  end

  assign sta.done = done;
  assign sta.ge   = acc >= PROD_BITS'({divisor, 1'b0});

endmodule

@@ src/touch_swipe_tap_recognizer.sv @@
// Touch swipe and tap recognizer: one result per touch poll.
// Each accepted poll passes through a start state, the bit-serial swipe length multiplier
// (one steps bit a cycle) and a commit state, which waits for the output register to free.
// A new poll is accepted only in the idle state, after the previous one has committed.
// A waiting result sits in the output register while the next poll is accepted.
// Synchronous reset restores the register defaults and the gesture state.
module touch_swipe_tap_recognizer
  import tstr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 poll_valid,
  output logic                 poll_ready,
  input  poll_t                poll,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [TICK_BITS-1:0] cfg_data
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_START  = 2'd1;
  localparam logic [1:0] S_MUL    = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state;

  logic [DIM_BITS-1:0]  screen_width;
  logic [DIM_BITS-1:0]  screen_height;
  logic [STEP_BITS-1:0] swipe_steps;
  logic [TICK_BITS-1:0] press_ticks;
  logic                 dim_enable;

  logic                  was_touched;
  logic [2:0]            gesture_dir;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] volume_anchor;
  logic [COORD_BITS-1:0] station_anchor;
  logic [TIME_BITS-1:0]  press_start;

  logic                  was_touched_next;
  logic [2:0]            gesture_dir_next;
  logic [COORD_BITS-1:0] start_x_next;
  logic [COORD_BITS-1:0] start_y_next;
  logic [COORD_BITS-1:0] volume_anchor_next;
  logic [COORD_BITS-1:0] station_anchor_next;
  logic [TIME_BITS-1:0]  press_start_next;
  result_t               result_next;

  poll_t    item;
  logic     swipe_ge;
  mul_req_t mreq;
  mul_sta_t msta;

  assign cfg_ready  = 1'b1;
  assign poll_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= DIM_BITS'(320);
      screen_height <= DIM_BITS'(240);
      swipe_steps   <= STEP_BITS'(40);
      press_ticks   <= TICK_BITS'(500);
      dim_enable    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data[DIM_BITS-1:0];
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data[DIM_BITS-1:0];
        CFG_SWIPE_STEPS:   swipe_steps   <= cfg_data[STEP_BITS-1:0];
        CFG_PRESS_TICKS:   press_ticks   <= cfg_data;
        CFG_DIM_ENABLE:    dim_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Classification of the held sample against the start point.
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS-1:0]      adx;
  logic [COORD_BITS-1:0]      ady;
  logic [2:0]                 cls;
  logic                       horiz;
  logic                       vert;

  always_comb begin
    dx  = $signed({1'b0, item.pos_x}) - $signed({1'b0, start_x});
    dy  = $signed({1'b0, item.pos_y}) - $signed({1'b0, start_y});
    adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    if (adx > COORD_BITS'(MOVE_LIMIT) || ady > COORD_BITS'(MOVE_LIMIT)) begin
      if (adx > ady) begin
        cls = (!dx[COORD_BITS] && dx != '0) ? DIR_RIGHT : DIR_LEFT;
      end else begin
        cls = (!dy[COORD_BITS] && dy != '0) ? DIR_DOWN : DIR_UP;
      end
    end else begin
      cls = DIR_REQUEST;
    end
    horiz = (cls == DIR_LEFT) || (cls == DIR_RIGHT);
    vert  = (cls == DIR_UP) || (cls == DIR_DOWN);
  end

  // Operands of the length test for whichever axis the swipe runs along.
  logic [COORD_BITS-1:0] anchor_sel;
  logic [COORD_BITS-1:0] pos_sel;

  always_comb begin
    anchor_sel   = horiz ? volume_anchor : station_anchor;
    pos_sel      = horiz ? item.pos_x : item.pos_y;
    mreq.start   = (state == S_START);
    mreq.span    = (anchor_sel > pos_sel) ? anchor_sel - pos_sel : pos_sel - anchor_sel;
    mreq.steps   = swipe_steps;
    mreq.divisor = horiz ? screen_width : screen_height;
  end

  tstr_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .sta (msta)
  );

  logic [TIME_BITS-1:0] held;
  logic                 keep;

  always_comb begin
    was_touched_next    = was_touched;
    gesture_dir_next    = gesture_dir;
    start_x_next        = start_x;
    start_y_next        = start_y;
    volume_anchor_next  = volume_anchor;
    station_anchor_next = station_anchor;
    press_start_next    = press_start;
    result_next         = '0;
    keep                = 1'b0;
    held                = item.now_ms - press_start;

    if (item.touched) begin
      if (!was_touched) begin
        start_x_next        = item.pos_x;
        start_y_next        = item.pos_y;
        volume_anchor_next  = item.pos_x;
        station_anchor_next = item.pos_y;
        gesture_dir_next    = DIR_REQUEST;
        press_start_next    = item.now_ms;
      end else begin
        gesture_dir_next = cls;
        if (horiz) begin
          press_start_next = item.now_ms;
          if (item.display_mode == MODE_PLAYER || item.display_mode == MODE_VOLUME) begin
            result_next.mode_request = REQ_VOLUME;
            if (swipe_ge) begin
              result_next.step_event = (volume_anchor < item.pos_x) ? STEP_INC : STEP_DEC;
              volume_anchor_next     = item.pos_x;
            end
          end
        end else if (vert) begin
          press_start_next = item.now_ms;
          if (item.display_mode == MODE_PLAYER || item.display_mode == MODE_STATIONS) begin
            result_next.mode_request = REQ_STATIONS;
            if (swipe_ge) begin
              result_next.step_event = (station_anchor < item.pos_y) ? STEP_INC : STEP_DEC;
              station_anchor_next    = item.pos_y;
            end
          end
        end
      end
      was_touched_next = 1'b1;
    end else begin
      if (was_touched) begin
        if (gesture_dir == DIR_REQUEST) begin
          if (held < TIME_BITS'({press_ticks, 1'b0})) begin
            if (held > TIME_BITS'(TAP_MIN_MS)) begin
              priority if (dim_enable && (item.bl_dimmed || item.bl_fading)) begin
                press_start_next = item.now_ms;
                result_next.wake = 1'b1;
                keep             = 1'b1;
              end else if (dim_enable && item.bl_just_woke) begin
                result_next.activity = 1'b1;
                keep                 = 1'b1;
              end else begin
                result_next.activity = dim_enable;
                result_next.click    = 1'b1;
              end
            end
          end else begin
            result_next.mode_request =
              (item.display_mode == MODE_PLAYER) ? REQ_STATIONS : REQ_PLAYER;
          end
        end
        if (!keep) begin
          gesture_dir_next = DIR_STAY;
        end
      end
      if (!keep) begin
        was_touched_next = 1'b0;
      end
    end
  end

  logic commit;
  assign commit = (state == S_COMMIT) && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      result_valid   <= 1'b0;
      was_touched    <= 1'b1;
      gesture_dir    <= DIR_STAY;
      start_x        <= '0;
      start_y        <= '0;
      volume_anchor  <= '0;
      station_anchor <= '0;
      press_start    <= '0;
    end else begin
      // A commit in the same cycle keeps result_valid high with the new result.
      if (result_valid && result_ready && !commit) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (poll_valid) begin
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_MUL;
        end
        S_MUL: begin
          if (msta.done) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (commit) begin
            state          <= S_IDLE;
            result_valid   <= 1'b1;
            was_touched    <= was_touched_next;
            gesture_dir    <= gesture_dir_next;
            start_x        <= start_x_next;
            start_y        <= start_y_next;
            volume_anchor  <= volume_anchor_next;
            station_anchor <= station_anchor_next;
            press_start    <= press_start_next;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (poll_valid && poll_ready) begin
      item <= poll;
    end
    if (state == S_MUL && msta.done) begin
      swipe_ge <= msta.ge;
    end
    if (commit) begin
      result <= result_next;
    end
  end

endmodule

@@ src/tstr_checker.sv @@
// Port-level checker for the touch recognizer and its bind to the top level.
`include "touch_swipe_tap_recognizer_assert.svh"

module tstr_checker
  import tstr_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    poll_valid,
  input logic    poll_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // A result that is not taken stays offered unchanged.
  `TSTR_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result))

  // A step is only ever issued together with a screen request.
  `TSTR_ASSERT_NOW(a_step_has_req, clk, rst, result_valid && result.step_event != STEP_NONE, result.mode_request == REQ_VOLUME || result.mode_request == REQ_STATIONS)

  // Tap outcomes exclude swipes, toggles and each other.
  `TSTR_ASSERT_NOW(a_tap_alone, clk, rst, result_valid && (result.click || result.wake), result.mode_request == REQ_NONE && result.step_event == STEP_NONE && !(result.click && result.wake))

  // One poll is worked on at a time.
  `TSTR_ASSERT_NEXT(a_one_at_a_time, clk, rst, poll_valid && poll_ready, !poll_ready)

endmodule

bind touch_swipe_tap_recognizer tstr_checker u_tstr_checker (
  .clk          (clk),
  .rst          (rst),
  .poll_valid   (poll_valid),
  .poll_ready   (poll_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
